// ===== hdl/msf_pkg.sv =====
// ----------------------------------------------------------------------------
// msf_pkg - shared constants for the maximal subset filter
// Sizes of the set store, the index and count widths, and the config reset.
// ----------------------------------------------------------------------------
package msf_pkg;

	localparam int MAX_SETS  = 64;
	localparam int MAX_WIDTH = 64;

	localparam int SET_W     = 64;
	localparam int ENTRY_W   = SET_W + 1;
	localparam int IDX_W     = $clog2(MAX_SETS);
	localparam int CNT_W     = $clog2(MAX_SETS + 1);
	localparam int ECNT_W    = 7;
	localparam int OUT_IDX_W = 6;

	localparam logic [ECNT_W-1:0] ELEM_COUNT_RESET = ECNT_W'(64);

endpackage

// ===== hdl/msf_if.sv =====
// ----------------------------------------------------------------------------
// msf_if - valid/ready channels of the maximal subset filter
// One channel for incoming sets and one for per-set results.
// ----------------------------------------------------------------------------
interface msf_set_if;
	logic                     valid;
	logic                     ready;
	logic [msf_pkg::SET_W-1:0] set_bits;
	logic                     initially_maximal;
	logic                     last_set;

	modport source (output valid, output set_bits, output initially_maximal,
		output last_set, input ready);
	modport sink (input valid, input set_bits, input initially_maximal,
		input last_set, output ready);
endinterface

interface msf_res_if;
	logic                         valid;
	logic                         ready;
	logic [msf_pkg::OUT_IDX_W-1:0] set_index;
	logic                         is_maximal;
	logic                         last_result;

	modport source (output valid, output set_index, output is_maximal,
		output last_result, input ready);
	modport sink (input valid, input set_index, input is_maximal,
		input last_result, output ready);
endinterface

// ===== hdl/msf_ram.sv =====
// ----------------------------------------------------------------------------
// msf_ram - generic single-port-write, single-port-read ram
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module msf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/maximal_subset_filter_unit.sv =====
// ----------------------------------------------------------------------------
// maximal_subset_filter_unit - marks the flagged sets of a list not contained in other flagged sets
// Loads a list of bit-vector sets, runs a pairwise containment pass over a
// shared ram read port and compare, then reports each set's final flag.
// ----------------------------------------------------------------------------
//
//  channel    | dir | beat payload                                  | kind
//  -----------+-----+-----------------------------------------------+-----------
//  sets       | in  | set_bits, initially_maximal, last_set         | valid/ready
//  results    | out | set_index, is_maximal, last_result            | valid/ready
//  cfg        | in  | cfg_wdata (element_count)                     | write enable
//
// Loading takes a set beat whenever sets.valid and sets.ready are high. After
// the beat with last_set the pass reads each set and, for a still active one,
// reads and compares the other sets in turn, stepping over the set itself,
// until one covers it, all through the one read port of the set ram. Results
// then leave one at a time, each read and registered before it is offered,
// the next read starting once the beat is taken. sets.ready is low from the
// last beat of a list until its final result is taken. arst_n clears the
// sequencer, set count and output valid; the set ram is not cleared.
// ----------------------------------------------------------------------------
module maximal_subset_filter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	msf_set_if.sink                       sets,
	msf_res_if.source                     results,
	input  logic                          cfg_we,
	input  logic [msf_pkg::ECNT_W-1:0]    cfg_wdata
);

	typedef enum logic [7:0] {
		S_LOAD  = 8'b0000_0001,
		S_IRD   = 8'b0000_0010,
		S_ICHK  = 8'b0000_0100,
		S_JRD   = 8'b0000_1000,
		S_JCHK  = 8'b0001_0000,
		S_ORD   = 8'b0010_0000,
		S_OLD   = 8'b0100_0000,
		S_OWAIT = 8'b1000_0000
	} state_t;

	state_t                        state_q, state_d;
	logic [msf_pkg::ECNT_W-1:0]    elem_count_q;
	logic [msf_pkg::CNT_W-1:0]     cnt_q, n_q, i_q, j_q, k_q;
	logic [msf_pkg::SET_W-1:0]     mask_q, seti_q, mask_d;
	logic [msf_pkg::ECNT_W-1:0]    width_c;
	logic                          out_valid_q, out_max_q, out_last_q;
	logic [msf_pkg::OUT_IDX_W-1:0] out_idx_q;

	logic                          ram_we, ram_re;
	logic [msf_pkg::IDX_W-1:0]     ram_waddr, ram_raddr;
	logic [msf_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;

	logic                          in_fire, out_fire, has_room, contained;
	logic [msf_pkg::CNT_W-1:0]     i_nxt, j_nxt;

	assign in_fire  = sets.valid && sets.ready;
	assign out_fire = results.valid && results.ready;
	assign has_room = cnt_q < msf_pkg::CNT_W'(msf_pkg::MAX_SETS);
	assign i_nxt    = i_q + msf_pkg::CNT_W'(1);
	assign j_nxt    = j_q + msf_pkg::CNT_W'(1);

	assign sets.ready          = (state_q == S_LOAD);
	assign results.valid       = out_valid_q;
	assign results.set_index   = out_idx_q;
	assign results.is_maximal  = out_max_q;
	assign results.last_result = out_last_q;

	// clamp the element count into 1..MAX_WIDTH and build the compare mask
	always_comb begin
		width_c = elem_count_q;
		if (width_c == '0) begin
			width_c = msf_pkg::ECNT_W'(1);
		end
		if (width_c > msf_pkg::ECNT_W'(msf_pkg::MAX_WIDTH)) begin
			width_c = msf_pkg::ECNT_W'(msf_pkg::MAX_WIDTH);
		end
		if (width_c >= msf_pkg::ECNT_W'(msf_pkg::SET_W)) begin
			mask_d = '1;
		end else begin
			mask_d = (msf_pkg::SET_W'(1) << width_c) - msf_pkg::SET_W'(1);
		end
	end

	// set i is covered by set j when j is still active and no masked bit of i lies outside j
	assign contained = ram_rdata[msf_pkg::SET_W] &&
		((seti_q & ~ram_rdata[msf_pkg::SET_W-1:0] & mask_q) == '0);

	msf_ram #(
		.WIDTH (msf_pkg::ENTRY_W),
		.DEPTH (msf_pkg::MAX_SETS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[msf_pkg::IDX_W-1:0];
		ram_wdata = {sets.initially_maximal, sets.set_bits};
		ram_re    = 1'b0;
		ram_raddr = i_q[msf_pkg::IDX_W-1:0];
		unique case (state_q)
			S_LOAD: begin
				ram_we = in_fire && has_room;
				if (in_fire && sets.last_set) begin
					state_d = S_IRD;
				end
			end
			S_IRD: begin
				ram_re  = 1'b1;
				state_d = S_ICHK;
			end
			S_ICHK: begin
				if (!ram_rdata[msf_pkg::SET_W]) begin
					state_d = (i_nxt == n_q) ? S_ORD : S_IRD;
				end else begin
					state_d = S_JRD;
				end
			end
			S_JRD: begin
				if (j_q == i_q) begin
					if (j_nxt == n_q) begin
						state_d = (i_nxt == n_q) ? S_ORD : S_IRD;
					end
				end else begin
					ram_re    = 1'b1;
					ram_raddr = j_q[msf_pkg::IDX_W-1:0];
					state_d   = S_JCHK;
				end
			end
			S_JCHK: begin
				if (contained) begin
					// clear the flag of set i in place
					ram_we    = 1'b1;
					ram_waddr = i_q[msf_pkg::IDX_W-1:0];
					ram_wdata = {1'b0, seti_q};
					state_d   = (i_nxt == n_q) ? S_ORD : S_IRD;
				end else if (j_nxt == n_q) begin
					state_d = (i_nxt == n_q) ? S_ORD : S_IRD;
				end else begin
					state_d = S_JRD;
				end
			end
			S_ORD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q[msf_pkg::IDX_W-1:0];
				state_d   = S_OLD;
			end
			S_OLD: begin
				state_d = S_OWAIT;
			end
			S_OWAIT: begin
				if (out_fire) begin
					state_d = out_last_q ? S_LOAD : S_ORD;
				end
			end
			default: begin
				state_d = S_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			elem_count_q <= msf_pkg::ELEM_COUNT_RESET;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				elem_count_q <= cfg_wdata;
			end
			if (state_q == S_LOAD && in_fire) begin
				if (sets.last_set) begin
					cnt_q <= '0;
				end else if (has_room) begin
					cnt_q <= cnt_q + msf_pkg::CNT_W'(1);
				end
			end
			if (state_q == S_OLD) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// pass counters and held operands
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LOAD: begin
				if (in_fire && sets.last_set) begin
					n_q    <= has_room ? cnt_q + msf_pkg::CNT_W'(1) : cnt_q;
					mask_q <= mask_d;
					i_q    <= '0;
					k_q    <= '0;
				end
			end
			S_IRD: begin
				j_q <= '0;
			end
			S_ICHK: begin
				seti_q <= ram_rdata[msf_pkg::SET_W-1:0];
				if (!ram_rdata[msf_pkg::SET_W]) begin
					i_q <= i_nxt;
				end
			end
			S_JRD: begin
				if (j_q == i_q) begin
					j_q <= j_nxt;
					if (j_nxt == n_q) begin
						i_q <= i_nxt;
					end
				end
			end
			S_JCHK: begin
				j_q <= j_nxt;
				if (contained || j_nxt == n_q) begin
					i_q <= i_nxt;
				end
			end
			S_ORD: begin
			end
			S_OLD: begin
				out_idx_q  <= msf_pkg::OUT_IDX_W'(k_q);
				out_max_q  <= ram_rdata[msf_pkg::SET_W];
				out_last_q <= (k_q + msf_pkg::CNT_W'(1) == n_q);
			end
			S_OWAIT: begin
				if (out_fire) begin
					k_q <= k_q + msf_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - maximal subset filter unit
// Sends lists of sets over the set channel and predicts, per list, the final
// maximal flag of every stored set after the in-place containment pass. Every
// result beat is checked against the oldest predicted verdict. The sender
// idles in bursts, the receiver stalls on its own pattern and holds off once
// per round so the unit backs up. element_count is rewritten between lists.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTED   = 10;
	localparam int VERDICT_DEPTH  = 256;
	localparam int RECENT_DEPTH   = 2 * msf_pkg::MAX_SETS;

	typedef struct packed {
		logic [msf_pkg::OUT_IDX_W-1:0] set_index;
		logic                          is_maximal;
		logic                          last_result;
	} verdict_t;

	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_PATTERN
	} rx_mode_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [msf_pkg::ECNT_W-1:0] cfg_wdata;

	msf_set_if sets_bus ();
	msf_res_if results_bus ();

	maximal_subset_filter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sets      (sets_bus),
		.results   (results_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [msf_pkg::SET_W-1:0]  held_sets [msf_pkg::MAX_SETS];
	logic                       held_flags [msf_pkg::MAX_SETS];
	int unsigned                held_count;
	logic [msf_pkg::ECNT_W-1:0] elem_count_model;
	// ring of verdicts still owed by the unit
	verdict_t                   verdict_ring [VERDICT_DEPTH];
	int                         verdict_wr;
	int                         verdict_rd;

	logic [msf_pkg::SET_W-1:0]  recent_sets [RECENT_DEPTH];
	int                         recent_count;
	int                         mismatch_count;
	int                         idle_cycles;
	bit                         sender_bursty;
	int                         burst_left;
	int                         hold_requests;

	initial begin
		clk = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// in-place pass: a set is cleared once some other still active set covers it
	function automatic void clear_covered_sets(int unsigned n,
			logic [msf_pkg::SET_W-1:0] mask);
		for (int unsigned i = 0; i < n; i++) begin
			if (!held_flags[i])
				continue;
			for (int unsigned j = 0; j < n; j++) begin
				if (j == i || !held_flags[j])
					continue;
				if ((held_sets[i] & ~held_sets[j] & mask) == '0) begin
					held_flags[i] = 1'b0;
					break;
				end
			end
		end
	endfunction

	function automatic void absorb_set_beat(logic [msf_pkg::SET_W-1:0] bits, logic cand,
			logic last);
		int unsigned               width;
		logic [msf_pkg::SET_W-1:0] mask;
		verdict_t                  v;
		if (held_count < msf_pkg::MAX_SETS) begin
			held_sets[held_count]  = bits;
			held_flags[held_count] = cand;
			held_count++;
		end
		if (!last)
			return;
		width = elem_count_model;
		if (width < 1)
			width = 1;
		if (width > msf_pkg::MAX_WIDTH)
			width = msf_pkg::MAX_WIDTH;
		mask = (width >= msf_pkg::SET_W) ? '1 :
			((msf_pkg::SET_W'(1) << width) - msf_pkg::SET_W'(1));
		clear_covered_sets(held_count, mask);
		for (int unsigned k = 0; k < held_count; k++) begin
			v.set_index   = k[msf_pkg::OUT_IDX_W-1:0];
			v.is_maximal  = held_flags[k];
			v.last_result = (k + 1 == held_count);
			verdict_ring[verdict_wr % VERDICT_DEPTH] = v;
			verdict_wr++;
		end
		held_count = 0;
	endfunction

	function automatic void flag_mismatch(string what, verdict_t want, verdict_t got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTED)
			$display("mismatch (%s): expected idx=%0d max=%0b last=%0b, got idx=%0d max=%0b last=%0b",
				what, want.set_index, want.is_maximal, want.last_result,
				got.set_index, got.is_maximal, got.last_result);
	endfunction

	// set beats feed the predictor
	always @(posedge clk) begin
		if (arst_n && sets_bus.valid && sets_bus.ready)
			absorb_set_beat(sets_bus.set_bits, sets_bus.initially_maximal, sets_bus.last_set);
	end

	// result beats against the oldest verdict
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && results_bus.valid && results_bus.ready) begin
			got.set_index   = results_bus.set_index;
			got.is_maximal  = results_bus.is_maximal;
			got.last_result = results_bus.last_result;
			if (verdict_wr == verdict_rd) begin
				flag_mismatch("no result expected", '0, got);
			end else begin
				want = verdict_ring[verdict_rd % VERDICT_DEPTH];
				verdict_rd++;
				if (got.set_index !== want.set_index || got.is_maximal !== want.is_maximal ||
						got.last_result !== want.last_result)
					flag_mismatch("field", want, got);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sets_bus.valid && sets_bus.ready) || (results_bus.valid && results_bus.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: stall modes drawn at random, plus requested hold-offs
	initial begin
		rx_mode_t mode;
		int       mode_left;
		int       hold_left;
		int       hold_seen;
		int       tick;
		results_bus.ready = 1'b0;
		mode      = RX_ALWAYS;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		tick      = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_bus.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 96);
				end
				mode_left--;
				case (mode)
					RX_ALWAYS: results_bus.ready <= 1'b1;
					RX_COIN: results_bus.ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: results_bus.ready <= ($urandom_range(0, 3) == 0);
					default: results_bus.ready <= ((tick % 7) < 4);
				endcase
			end
		end
	end

	task automatic send_set(logic [msf_pkg::SET_W-1:0] bits, logic cand, logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_bursty ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				sets_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sets_bus.valid             <= 1'b1;
		sets_bus.set_bits          <= bits;
		sets_bus.initially_maximal <= cand;
		sets_bus.last_set          <= last;
		@(posedge clk);
		while (!sets_bus.ready)
			@(posedge clk);
	endtask

	// drop valid and let the predictor see the last beat before waiting on the verdicts
	task automatic wait_drained();
		sets_bus.valid <= 1'b0;
		@(posedge clk);
		while (verdict_wr != verdict_rd)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_element_count(logic [msf_pkg::ECNT_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		elem_count_model = value;
	endtask

	function automatic logic [msf_pkg::SET_W-1:0] draw_set();
		logic [msf_pkg::SET_W-1:0] base;
		logic [msf_pkg::SET_W-1:0] noise;
		noise = {$urandom, $urandom};
		if (recent_count > 0)
			base = recent_sets[$urandom_range(0, recent_count - 1)];
		else
			base = noise;
		case ($urandom_range(0, 9))
			0, 1: draw_set = noise;
			2: draw_set = noise & {$urandom, $urandom} & {$urandom, $urandom};
			3: draw_set = noise &
				((msf_pkg::SET_W'(1) << $urandom_range(1, 12)) - msf_pkg::SET_W'(1));
			// subset of an earlier set of the list
			4, 5: draw_set = base & noise;
			6: draw_set = base | (noise & {$urandom, $urandom} & {$urandom, $urandom});
			7: draw_set = base;
			8: draw_set = '0;
			default: draw_set = '1;
		endcase
	endfunction

	task automatic send_list(int len);
		logic [msf_pkg::SET_W-1:0] bits;
		recent_count = 0;
		for (int k = 0; k < len; k++) begin
			bits = draw_set();
			if (recent_count < RECENT_DEPTH) begin
				recent_sets[recent_count] = bits;
				recent_count++;
			end
			send_set(bits, $urandom_range(0, 7) != 0, k == len - 1);
		end
	endtask

	task automatic test_directed();
		sender_bursty = 1'b1;
		// lone sets, candidate and not
		send_set('1, 1'b1, 1'b1);
		send_set('0, 1'b0, 1'b1);
		// duplicates, an empty set, a full set and a wide set
		send_set(64'h0000_0000_0000_00f0, 1'b1, 1'b0);
		send_set(64'h0000_0000_0000_00f0, 1'b1, 1'b0);
		send_set('0, 1'b1, 1'b0);
		send_set('1, 1'b1, 1'b0);
		send_set(64'h8000_0000_0000_0001, 1'b1, 1'b1);
		// empty set stays when every other set is inactive
		send_set('0, 1'b1, 1'b0);
		send_set('1, 1'b0, 1'b1);
		// chain with an inactive middle
		send_set(64'h1, 1'b1, 1'b0);
		send_set(64'h3, 1'b0, 1'b0);
		send_set(64'h7, 1'b1, 1'b1);
		wait_drained();
		// bits above the width are ignored
		write_element_count(msf_pkg::ECNT_W'(4));
		send_set(64'h10, 1'b1, 1'b0);
		send_set(64'h20, 1'b1, 1'b0);
		send_set(64'h3, 1'b1, 1'b0);
		send_set(64'h1, 1'b1, 1'b1);
		wait_drained();
		// zero width acts as one element
		write_element_count(msf_pkg::ECNT_W'(0));
		send_set(64'h2, 1'b1, 1'b0);
		send_set(64'h1, 1'b1, 1'b1);
		wait_drained();
		// widths above the maximum act as the maximum
		write_element_count(msf_pkg::ECNT_W'(127));
		send_set(64'h8000_0000_0000_0000, 1'b1, 1'b0);
		send_set(64'h8000_0000_0000_0001, 1'b1, 1'b1);
		wait_drained();
		write_element_count(msf_pkg::ECNT_W'(65));
		send_set(64'h8000_0000_0000_0000, 1'b1, 1'b0);
		send_set(64'h1, 1'b1, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_lists();
		logic [msf_pkg::ECNT_W-1:0] widths [10];
		int                         sent;
		int                         len;
		int                         pick;
		widths = '{msf_pkg::ECNT_W'(1), msf_pkg::ECNT_W'(64), msf_pkg::ECNT_W'(0),
			msf_pkg::ECNT_W'(127), msf_pkg::ECNT_W'(2), msf_pkg::ECNT_W'(65),
			msf_pkg::ECNT_W'(33), msf_pkg::ECNT_W'($urandom_range(0, 127)),
			msf_pkg::ECNT_W'($urandom_range(1, 16)), msf_pkg::ECNT_W'(8)};
		foreach (widths[p]) begin
			write_element_count(widths[p]);
			sender_bursty = ($urandom_range(0, 3) != 0);
			sent = 0;
			while (sent < 20) begin
				pick = $urandom_range(0, 19);
				if (pick < 15)
					len = $urandom_range(1, 10);
				else if (pick < 19)
					len = $urandom_range(11, 24);
				else
					len = $urandom_range(40, 64);
				send_list(len);
				sent += len;
			end
			wait_drained();
		end
	endtask

	// a full store, then a list whose tail is dropped but still starts the pass
	task automatic test_overflow();
		write_element_count(msf_pkg::ECNT_W'(64));
		sender_bursty = 1'b1;
		send_list(msf_pkg::MAX_SETS);
		send_list(msf_pkg::MAX_SETS + $urandom_range(1, 3));
		wait_drained();
	endtask

	task automatic test_backpressure();
		sender_bursty = 1'b0;
		for (int r = 0; r < 2; r++) begin
			write_element_count(msf_pkg::ECNT_W'($urandom_range(1, 64)));
			hold_requests++;
			send_list($urandom_range(4, 8));
			send_list($urandom_range(4, 8));
			send_list($urandom_range(2, 5));
			wait_drained();
		end
	endtask

	initial begin
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_wdata                  = '0;
		sets_bus.valid             = 1'b0;
		sets_bus.set_bits          = '0;
		sets_bus.initially_maximal = 1'b0;
		sets_bus.last_set          = 1'b0;
		held_count                 = 0;
		elem_count_model           = msf_pkg::ELEM_COUNT_RESET;
		verdict_wr                 = 0;
		verdict_rd                 = 0;
		recent_count               = 0;
		mismatch_count             = 0;
		idle_cycles                = 0;
		sender_bursty              = 1'b1;
		burst_left                 = 0;
		hold_requests              = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_random_lists();
		test_overflow();
		test_backpressure();

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && verdict_wr == verdict_rd)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
